>>> sv/pfs_pkg.sv
// ----------------------------------------------------------------------------
// pfs_pkg: shared types and constants for the parallel port sound fifo
// Holds the fifo depth, the derived widths, the port decode constants, the
// item function codes and the control/status structs used between modules.
// ----------------------------------------------------------------------------
package pfs_pkg;

   // fifo geometry, valid from 2 to 256 entries
   localparam int FIFO_DEPTH = 16;
   localparam int PTR_W      = $clog2(FIFO_DEPTH);
   localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

   // field widths
   localparam int FUNC_W   = 2;
   localparam int PORT_W   = 16;
   localparam int DATA_W   = 8;
   localparam int STATUS_W = 7;

   // port decode and protocol constants
   localparam logic [PORT_W-1:0]   DATA_PORT   = 16'h0378;
   localparam logic [PORT_W-1:0]   CTRL_PORT   = 16'h037A;
   localparam logic [STATUS_W-1:0] FULL_FLAG   = 7'h40;
   localparam logic [DATA_W-1:0]   ENABLE_CODE = 8'h04;
   localparam logic [1:0]          PROBES_NEEDED = 2'd2;

   // item function codes
   typedef enum logic [FUNC_W-1:0] {
      FUNC_WRITE = 2'd0,
      FUNC_READ  = 2'd1,
      FUNC_TICK  = 2'd2
   } func_type;

   // fifo control from the item decode
   typedef struct packed {
      logic push;
      logic pop;
   } fifo_ctrl_type;

   // fifo status back to the item decode
   typedef struct packed {
      logic full;
      logic empty;
   } fifo_stat_type;

endpackage

>>> sv/parallel_port_sound_fifo_core.sv
// ----------------------------------------------------------------------------
// parallel_port_sound_fifo_core: parallel port sound source with sample fifo
// Decodes port writes, status reads and sample ticks against a byte fifo.
// ----------------------------------------------------------------------------
// The block takes one item per clock while the output side is not stalled and
// gives exactly one result per item, in order. An accepted item lands in an
// input register; when the output register is free or being taken, the decode
// and fifo update run and the result is captured in the output register, where
// it is held until the output side takes it. A stalled output holds the result
// while the input register still accepts one more item. The fifo update is a
// single pointer and count step per item, which sets the one item per cycle
// rate.
// ----------------------------------------------------------------------------
module parallel_port_sound_fifo_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [pfs_pkg::FUNC_W-1:0]     req_func,
   input  logic [pfs_pkg::PORT_W-1:0]     req_port,
   input  logic [pfs_pkg::DATA_W-1:0]     req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [pfs_pkg::STATUS_W-1:0]   rsp_status,
   output logic [pfs_pkg::DATA_W-1:0]     rsp_sample
);

   logic                           stage_valid_ff, stage_valid_in;
   logic [pfs_pkg::FUNC_W-1:0]     stage_func_ff;
   logic [pfs_pkg::PORT_W-1:0]     stage_port_ff;
   logic [pfs_pkg::DATA_W-1:0]     stage_data_ff;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [pfs_pkg::STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [pfs_pkg::DATA_W-1:0]     rsp_sample_ff, rsp_sample_in;

   logic                           active_ff, active_in;
   logic [1:0]                     probes_ff, probes_in;

   logic                           advance;
   logic                           req_xfer;
   pfs_pkg::fifo_ctrl_type         fifo_ctrl;
   pfs_pkg::fifo_stat_type         fifo_stat;
   logic [pfs_pkg::DATA_W-1:0]     fifo_head;

   // handshake
   assign advance   = stage_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !stage_valid_ff || advance;
   assign req_xfer  = req_valid && req_ready;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_sample = rsp_sample_ff;

   // sample fifo
   pfs_fifo u_fifo (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (fifo_ctrl),
      .wr_data (stage_data_ff),
      .stat    (fifo_stat),
      .rd_data (fifo_head)
   );

   // item decode and state update
   always_comb begin
      fifo_ctrl      = '0;
      active_in      = active_ff;
      probes_in      = probes_ff;
      rsp_status_in  = '0;
      rsp_sample_in  = '0;
      if (advance) begin
         unique case (stage_func_ff)
            pfs_pkg::FUNC_WRITE: begin
               if (stage_port_ff == pfs_pkg::DATA_PORT) begin
                  fifo_ctrl.push = !fifo_stat.full;
               end else if (stage_port_ff == pfs_pkg::CTRL_PORT &&
                            stage_data_ff == pfs_pkg::ENABLE_CODE) begin
                  active_in = 1'b1;
               end
            end
            pfs_pkg::FUNC_READ: begin
               if (probes_ff < pfs_pkg::PROBES_NEEDED) begin
                  probes_in = probes_ff + 1'b1;
               end
               rsp_status_in = fifo_stat.full ? pfs_pkg::FULL_FLAG : '0;
            end
            pfs_pkg::FUNC_TICK: begin
               if (!fifo_stat.empty && active_ff &&
                   probes_ff >= pfs_pkg::PROBES_NEEDED) begin
                  fifo_ctrl.pop = 1'b1;
                  rsp_sample_in = fifo_head;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // valid tracking for the two registers
   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (req_xfer) begin
         stage_valid_in = 1'b1;
      end else if (advance) begin
         stage_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         active_ff      <= 1'b0;
         probes_ff      <= '0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         active_ff      <= active_in;
         probes_ff      <= probes_in;
      end
   end

   // input register payload
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         stage_func_ff <= req_func;
         stage_port_ff <= req_port;
         stage_data_ff <= req_data;
      end
   end

   // result register payload
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_status_ff <= rsp_status_in;
         rsp_sample_ff <= rsp_sample_in;
      end
   end

endmodule

>>> sv/pfs_fifo.sv
// ----------------------------------------------------------------------------
// pfs_fifo: sample byte fifo
// Circular buffer of sample bytes with head and tail pointers and a fill
// count. The oldest byte is always presented on rd_data.
// ----------------------------------------------------------------------------
module pfs_fifo (
   input  logic                          clock,
   input  logic                          reset,
   input  pfs_pkg::fifo_ctrl_type        ctrl,
   input  logic [pfs_pkg::DATA_W-1:0]    wr_data,
   output pfs_pkg::fifo_stat_type        stat,
   output logic [pfs_pkg::DATA_W-1:0]    rd_data
);

   localparam logic [pfs_pkg::PTR_W-1:0] LAST_PTR = pfs_pkg::PTR_W'(pfs_pkg::FIFO_DEPTH - 1);
   localparam logic [pfs_pkg::CNT_W-1:0] FULL_CNT = pfs_pkg::CNT_W'(pfs_pkg::FIFO_DEPTH);

   logic [pfs_pkg::DATA_W-1:0] store_ff [pfs_pkg::FIFO_DEPTH];
   logic [pfs_pkg::PTR_W-1:0]  head_ff, head_in;
   logic [pfs_pkg::PTR_W-1:0]  tail_ff, tail_in;
   logic [pfs_pkg::CNT_W-1:0]  count_ff, count_in;

   // status and oldest byte
   assign stat.full  = (count_ff == FULL_CNT);
   assign stat.empty = (count_ff == '0);
   assign rd_data    = store_ff[head_ff];

   // pointer and count update, wrap at the last entry
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (ctrl.push) begin
         tail_in  = (tail_ff == LAST_PTR) ? '0 : tail_ff + 1'b1;
         count_in = count_ff + 1'b1;
      end else if (ctrl.pop) begin
         head_in  = (head_ff == LAST_PTR) ? '0 : head_ff + 1'b1;
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // sample storage, no reset needed: only written entries are ever popped
   always_ff @(posedge clock) begin
      if (ctrl.push) begin
         store_ff[tail_ff] <= wr_data;
      end
   end

endmodule
